// ===== rtl/ula_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ula_pkg - shared types and constants for the ultrasonic level alarm
// Level codes, register indexes, reset values and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package ula_pkg;

	localparam int TIMER_WIDTH     = 16;
	localparam int ECHO_WIDTH      = 15;
	localparam int DIST_WIDTH      = 10;
	localparam int THR_WIDTH       = 16;
	localparam int TONE_WIDTH      = 11;
	localparam int CFG_IDX_WIDTH   = 3;
	localparam int CFG_DATA_WIDTH  = 16;

	localparam int US_PER_CM       = 58;
	localparam int ECHO_TIMEOUT_US = 30000;

	// echo / 58 as a multiply by ceil(2^21 / 58) and a shift
	localparam int RECIP_SHIFT     = 21;
	localparam int RECIP_58        = ((1 << RECIP_SHIFT) + US_PER_CM - 1) / US_PER_CM;
	localparam int RECIP_WIDTH     = 16;
	localparam int PROD_WIDTH      = ECHO_WIDTH + RECIP_WIDTH;

	localparam logic [THR_WIDTH-1:0] SAFE_THR_RST  = THR_WIDTH'(25 * US_PER_CM);
	localparam logic [THR_WIDTH-1:0] ALERT_THR_RST = THR_WIDTH'(12 * US_PER_CM);
	localparam logic [THR_WIDTH-1:0] MAX_THR_RST   = THR_WIDTH'(400 * US_PER_CM);

	localparam logic [TIMER_WIDTH-1:0] SLOW_ON_RST    = TIMER_WIDTH'(200);
	localparam logic [TIMER_WIDTH-1:0] SLOW_OFF_RST   = TIMER_WIDTH'(800);
	localparam logic [TIMER_WIDTH-1:0] FAST_HALF_RST  = TIMER_WIDTH'(150);
	localparam logic [TIMER_WIDTH-1:0] ERROR_HALF_RST = TIMER_WIDTH'(250);

	localparam logic [TONE_WIDTH-1:0] TONE_NONE   = TONE_WIDTH'(0);
	localparam logic [TONE_WIDTH-1:0] TONE_ALERT  = TONE_WIDTH'(1000);
	localparam logic [TONE_WIDTH-1:0] TONE_DANGER = TONE_WIDTH'(1500);
	localparam logic [TONE_WIDTH-1:0] TONE_ERROR  = TONE_WIDTH'(700);

	typedef enum logic [1:0] {
		LVL_SAFE   = 2'd0,
		LVL_ALERT  = 2'd1,
		LVL_DANGER = 2'd2,
		LVL_ERROR  = 2'd3
	} ula_level_t;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_SAFE_LIMIT  = 3'd0,
		CFG_ALERT_LIMIT = 3'd1,
		CFG_MAX_VALID   = 3'd2,
		CFG_SLOW_ON     = 3'd3,
		CFG_SLOW_OFF    = 3'd4,
		CFG_FAST_HALF   = 3'd5,
		CFG_ERROR_HALF  = 3'd6
	} ula_cfg_idx_t;

	typedef struct packed {
		logic [TIMER_WIDTH-1:0] slow_on;
		logic [TIMER_WIDTH-1:0] slow_off;
		logic [TIMER_WIDTH-1:0] fast_half;
		logic [TIMER_WIDTH-1:0] error_half;
	} ula_beep_cfg_t;

endpackage

// ===== rtl/ultrasonic_level_alarm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_level_alarm - water level alarm from ultrasonic echo times
// Classifies echo times into safe, alert, danger or sensor error and drives
// the RGB LED, beeper cadence and tone code once per millisecond tick.
// ----------------------------------------------------------------------------
// Each request is one millisecond tick. A request is registered on entry and
// its result moves from that input register into the status registers when
// the result channel is not stalled; a new request is taken every cycle
// while results are collected, and the one multiplier for the distance and the
// limit compares sit in that single stage. Limits are scaled to microseconds
// when written, so configuration writes are taken every cycle.
module ultrasonic_level_alarm import ula_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      action,
	input  logic [ECHO_WIDTH-1:0]     echo_us,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                level_status,
	output logic                      led_red,
	output logic                      led_green,
	output logic                      led_blue,
	output logic                      beeper_on,
	output logic [TONE_WIDTH-1:0]     tone_hz,
	output logic [DIST_WIDTH-1:0]     distance_cm
);

	logic [THR_WIDTH-1:0] safe_thr_q, alert_thr_q, max_thr_q;
	ula_beep_cfg_t        beep_cfg_q;
	logic [THR_WIDTH-1:0] cfg_thr;

	logic                  valid_s1;
	logic                  action_s1;
	logic [ECHO_WIDTH-1:0] echo_s1;
	logic                  advance;

	ula_level_t            level_q, level_d;
	logic [DIST_WIDTH-1:0] dist_q, dist_d;
	logic                  out_valid_q;
	logic                  beep_active;

	logic [THR_WIDTH-1:0]  echo_ext;
	logic [PROD_WIDTH-1:0] recip_prod;
	logic                  echo_bad;

	// configuration
	assign cfg_ready = 1'b1;
	assign cfg_thr   = THR_WIDTH'(cfg_data[DIST_WIDTH-1:0]) * THR_WIDTH'(US_PER_CM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safe_thr_q            <= SAFE_THR_RST;
			alert_thr_q           <= ALERT_THR_RST;
			max_thr_q             <= MAX_THR_RST;
			beep_cfg_q.slow_on    <= SLOW_ON_RST;
			beep_cfg_q.slow_off   <= SLOW_OFF_RST;
			beep_cfg_q.fast_half  <= FAST_HALF_RST;
			beep_cfg_q.error_half <= ERROR_HALF_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SAFE_LIMIT:  safe_thr_q            <= cfg_thr;
				CFG_ALERT_LIMIT: alert_thr_q           <= cfg_thr;
				CFG_MAX_VALID:   max_thr_q             <= cfg_thr;
				CFG_SLOW_ON:     beep_cfg_q.slow_on    <= cfg_data;
				CFG_SLOW_OFF:    beep_cfg_q.slow_off   <= cfg_data;
				CFG_FAST_HALF:   beep_cfg_q.fast_half  <= cfg_data;
				CFG_ERROR_HALF:  beep_cfg_q.error_half <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			echo_s1   <= echo_us;
		end
	end

	// measurement
	assign echo_ext   = THR_WIDTH'(echo_s1);
	assign recip_prod = PROD_WIDTH'(echo_s1) * PROD_WIDTH'(RECIP_58);
	assign echo_bad   = (echo_s1 == '0) || (echo_ext > THR_WIDTH'(ECHO_TIMEOUT_US))
		|| (echo_ext > max_thr_q);

	always_comb begin
		level_d = level_q;
		dist_d  = dist_q;
		if (action_s1) begin
			priority if (echo_bad) begin
				level_d = LVL_ERROR;
				dist_d  = '0;
			end else if (echo_ext > safe_thr_q) begin
				level_d = LVL_SAFE;
				dist_d  = recip_prod[RECIP_SHIFT +: DIST_WIDTH];
			end else if (echo_ext > alert_thr_q) begin
				level_d = LVL_ALERT;
				dist_d  = recip_prod[RECIP_SHIFT +: DIST_WIDTH];
			end else begin
				level_d = LVL_DANGER;
				dist_d  = recip_prod[RECIP_SHIFT +: DIST_WIDTH];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= LVL_ERROR;
			dist_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				level_q <= level_d;
				dist_q  <= dist_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	ula_beeper u_beeper (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.level    (level_d),
		.beep_cfg (beep_cfg_q),
		.active   (beep_active)
	);

	// result decode
	always_comb begin
		tone_hz = TONE_NONE;
		if (beep_active) begin
			unique case (level_q)
				LVL_ALERT:  tone_hz = TONE_ALERT;
				LVL_DANGER: tone_hz = TONE_DANGER;
				LVL_ERROR:  tone_hz = TONE_ERROR;
				default:    tone_hz = TONE_NONE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign level_status = level_q;
	assign led_red      = (level_q == LVL_ALERT) || (level_q == LVL_DANGER);
	assign led_green    = (level_q == LVL_SAFE) || (level_q == LVL_ALERT);
	assign led_blue     = (level_q == LVL_ERROR);
	assign beeper_on    = beep_active;
	assign distance_cm  = dist_q;

endmodule

// ===== rtl/ula_beeper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ula_beeper - beeper cadence
// Saturating millisecond counter and on/off phase per status; a change of
// status restarts the beep, safe silences it.
// ----------------------------------------------------------------------------
module ula_beeper import ula_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  ula_level_t    level,
	input  ula_beep_cfg_t beep_cfg,
	output logic          active
);

	logic                   active_q, active_d;
	ula_level_t             prev_q, prev_d;
	logic [TIMER_WIDTH-1:0] elapsed_q, elapsed_d;
	logic [TIMER_WIDTH-1:0] elapsed_inc;
	logic [TIMER_WIDTH-1:0] phase_len;

	always_comb begin
		elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
		unique case (level)
			LVL_ALERT:  phase_len = active_q ? beep_cfg.slow_on : beep_cfg.slow_off;
			LVL_DANGER: phase_len = beep_cfg.fast_half;
			default:    phase_len = beep_cfg.error_half;
		endcase
	end

	always_comb begin
		active_d  = active_q;
		prev_d    = prev_q;
		elapsed_d = elapsed_q;
		if (step) begin
			priority if (level == LVL_SAFE) begin
				active_d  = 1'b0;
				prev_d    = LVL_SAFE;
				elapsed_d = elapsed_inc;
			end else if (level != prev_q) begin
				active_d  = 1'b1;
				prev_d    = level;
				elapsed_d = '0;
			end else if (elapsed_inc >= phase_len) begin
				active_d  = ~active_q;
				elapsed_d = '0;
			end else begin
				elapsed_d = elapsed_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			prev_q    <= LVL_ERROR;
			elapsed_q <= '0;
		end else begin
			active_q  <= active_d;
			prev_q    <= prev_d;
			elapsed_q <= elapsed_d;
		end
	end

	assign active = active_q;

endmodule

// ===== rtl/ula_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ula_checker - port level checks for the ultrasonic level alarm
// Watches the result channel: results held while stalled; status, LED, beeper, tone and distance agree.
// ----------------------------------------------------------------------------
module ula_checker import ula_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [1:0]            level_status,
	input logic                  led_blue,
	input logic                  beeper_on,
	input logic [TONE_WIDTH-1:0] tone_hz,
	input logic [DIST_WIDTH-1:0] distance_cm
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_silent_tone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !beeper_on |-> tone_hz == TONE_NONE)
		else $error("tone without beeper");

	a_safe_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && level_status == LVL_SAFE |-> !beeper_on)
		else $error("beeper sounding while safe");

	a_error_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && level_status == LVL_ERROR |-> distance_cm == '0 && led_blue)
		else $error("sensor error with distance or without blue");

endmodule

bind ultrasonic_level_alarm ula_checker u_ula_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.level_status (level_status),
	.led_blue     (led_blue),
	.beeper_on    (beeper_on),
	.tone_hz      (tone_hz),
	.distance_cm  (distance_cm)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for ultrasonic_level_alarm
// Feeds echo ticks through the request channel at random pace, works out the
// expected status, LED drive, beeper cadence, tone and distance per tick, and
// compares every result in order. Several register settings are visited,
// extremes and crossed limits among them, each written while the block idles.
// ----------------------------------------------------------------------------
module testbench;
	import ula_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int TIMER_MAX   = (1 << TIMER_WIDTH) - 1;

	typedef struct packed {
		ula_level_t              level;
		logic                    red;
		logic                    green;
		logic                    blue;
		logic                    beep;
		logic [TONE_WIDTH-1:0]   tone;
		logic [DIST_WIDTH-1:0]   dist_cm;
	} alarm_status_t;

	class alarm_board;
		int unsigned   safe_cm, alert_cm, max_cm;
		int unsigned   slow_on, slow_off, fast_half, error_half;
		ula_level_t    level, beep_level;
		bit            beep;
		int unsigned   dist_cm, elapsed;
		alarm_status_t status_q[$];
		int            errors, checked, beeps;
		int            level_seen[4];

		function new();
			safe_cm    = 25;
			alert_cm   = 12;
			max_cm     = 400;
			slow_on    = 200;
			slow_off   = 800;
			fast_half  = 150;
			error_half = 250;
			level      = LVL_ERROR;
			beep_level = LVL_ERROR;
			beep       = 1'b0;
			dist_cm    = 0;
			elapsed    = 0;
		endfunction

		function void set_reg(ula_cfg_idx_t idx, logic [CFG_DATA_WIDTH-1:0] value);
			case (idx)
				CFG_SAFE_LIMIT:  safe_cm    = value[DIST_WIDTH-1:0];
				CFG_ALERT_LIMIT: alert_cm   = value[DIST_WIDTH-1:0];
				CFG_MAX_VALID:   max_cm     = value[DIST_WIDTH-1:0];
				CFG_SLOW_ON:     slow_on    = value;
				CFG_SLOW_OFF:    slow_off   = value;
				CFG_FAST_HALF:   fast_half  = value;
				CFG_ERROR_HALF:  error_half = value;
				default: ;
			endcase
		endfunction

		function int pending();
			return status_q.size();
		endfunction

		// one millisecond tick: optional measurement, then the beeper cadence
		function void note_tick(logic act, logic [ECHO_WIDTH-1:0] echo_raw);
			int unsigned   echo, on_ms, off_ms;
			alarm_status_t want;
			echo = echo_raw;
			if (act) begin
				if (echo == 0 || echo > ECHO_TIMEOUT_US || echo > max_cm * US_PER_CM) begin
					level   = LVL_ERROR;
					dist_cm = 0;
				end else begin
					dist_cm = (echo / US_PER_CM) & 10'h3ff;
					if (echo > safe_cm * US_PER_CM)
						level = LVL_SAFE;
					else if (echo > alert_cm * US_PER_CM)
						level = LVL_ALERT;
					else
						level = LVL_DANGER;
				end
			end
			if (elapsed < TIMER_MAX)
				elapsed++;
			case (level)
				LVL_ALERT: begin
					on_ms  = slow_on;
					off_ms = slow_off;
				end
				LVL_DANGER: begin
					on_ms  = fast_half;
					off_ms = fast_half;
				end
				default: begin
					on_ms  = error_half;
					off_ms = error_half;
				end
			endcase
			if (level == LVL_SAFE) begin
				beep       = 1'b0;
				beep_level = LVL_SAFE;
			end else if (level != beep_level) begin
				beep_level = level;
				beep       = 1'b1;
				elapsed    = 0;
			end else if (elapsed >= (beep ? on_ms : off_ms)) begin
				elapsed = 0;
				beep    = !beep;
			end
			want.level = level;
			want.red   = (level == LVL_ALERT || level == LVL_DANGER);
			want.green = (level == LVL_SAFE || level == LVL_ALERT);
			want.blue  = (level == LVL_ERROR);
			want.beep  = beep;
			want.tone  = TONE_NONE;
			if (beep) begin
				case (level)
					LVL_ALERT:  want.tone = TONE_ALERT;
					LVL_DANGER: want.tone = TONE_DANGER;
					LVL_ERROR:  want.tone = TONE_ERROR;
					default:    want.tone = TONE_NONE;
				endcase
			end
			want.dist_cm = DIST_WIDTH'(dist_cm);
			status_q.push_back(want);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_status(alarm_status_t got);
			alarm_status_t want;
			if (status_q.size() == 0) begin
				$error("status result with no tick outstanding");
				errors++;
				return;
			end
			want = status_q.pop_front();
			compare_field("level_status", want.level,   got.level);
			compare_field("led_red",      want.red,     got.red);
			compare_field("led_green",    want.green,   got.green);
			compare_field("led_blue",     want.blue,    got.blue);
			compare_field("beeper_on",    want.beep,    got.beep);
			compare_field("tone_hz",      want.tone,    got.tone);
			compare_field("distance_cm",  want.dist_cm, got.dist_cm);
			checked++;
			if (want.beep)
				beeps++;
			level_seen[want.level]++;
		endfunction
	endclass

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_WIDTH-1:0]  cfg_index = CFG_SAFE_LIMIT;
	logic [CFG_DATA_WIDTH-1:0] cfg_data  = '0;
	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	logic                      action    = 1'b0;
	logic [ECHO_WIDTH-1:0]     echo_us   = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [1:0]                level_status;
	logic                      led_red;
	logic                      led_green;
	logic                      led_blue;
	logic                      beeper_on;
	logic [TONE_WIDTH-1:0]     tone_hz;
	logic [DIST_WIDTH-1:0]     distance_cm;

	alarm_board board = new();
	bit         jitter = 1'b1;
	int         cycles;
	int         sent_ticks;
	int         settings_used;

	ultrasonic_level_alarm DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.echo_us      (echo_us),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.level_status (level_status),
		.led_red      (led_red),
		.led_green    (led_green),
		.led_blue     (led_blue),
		.beeper_on    (beeper_on),
		.tone_hz      (tone_hz),
		.distance_cm  (distance_cm)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL ultrasonic_level_alarm");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= !(jitter && $urandom_range(99) < 16);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.set_reg(ula_cfg_idx_t'(cfg_index), cfg_data);
			if (in_valid && in_ready)
				board.note_tick(action, echo_us);
			if (out_valid && out_ready)
				board.check_status('{ula_level_t'(level_status), led_red, led_green,
					led_blue, beeper_on, tone_hz, distance_cm});
		end
	end

	task automatic send_tick(input bit act, input int unsigned echo);
		if (jitter && $urandom_range(99) < 16) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		action   = act;
		echo_us  = ECHO_WIDTH'(echo);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_ticks++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (board.pending() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input ula_cfg_idx_t idx, input int unsigned value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = CFG_DATA_WIDTH'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic configure(input int unsigned safe_cm, alert_cm, max_cm,
		slow_on, slow_off, fast_half, error_half);
		drain();
		write_reg(CFG_SAFE_LIMIT,  safe_cm);
		write_reg(CFG_ALERT_LIMIT, alert_cm);
		write_reg(CFG_MAX_VALID,   max_cm);
		write_reg(CFG_SLOW_ON,     slow_on);
		write_reg(CFG_SLOW_OFF,    slow_off);
		write_reg(CFG_FAST_HALF,   fast_half);
		write_reg(CFG_ERROR_HALF,  error_half);
		cfg_valid = 1'b0;
		settings_used++;
	endtask

	// echo aimed at the current limits: band edges, bands, zero echoes, beyond range
	function automatic int unsigned pick_echo();
		int          e;
		int unsigned lim;
		e = 0;
		case ($urandom_range(7))
			0: e = 0;
			1: e = $urandom_range(1, ECHO_TIMEOUT_US);
			2, 3: begin
				case ($urandom_range(2))
					0:       lim = board.safe_cm;
					1:       lim = board.alert_cm;
					default: lim = board.max_cm;
				endcase
				e = int'(lim * US_PER_CM) + int'($urandom_range(0, 2)) - 1;
			end
			7: begin
				if (board.max_cm * US_PER_CM < ECHO_TIMEOUT_US)
					e = $urandom_range(board.max_cm * US_PER_CM + 1, ECHO_TIMEOUT_US);
				else
					e = ECHO_TIMEOUT_US;
			end
			default: e = $urandom_range(0, board.max_cm) * US_PER_CM + $urandom_range(0, 57);
		endcase
		if (e < 0)
			e = 0;
		if (e > ECHO_TIMEOUT_US)
			e = ECHO_TIMEOUT_US;
		return e;
	endfunction

	// a measurement followed by a run of plain ticks, with the odd re-measure
	task automatic run_bursts(input int n);
		int          stop_at;
		int unsigned echo;
		stop_at = sent_ticks + n;
		while (sent_ticks < stop_at) begin
			echo = pick_echo();
			send_tick(1'b1, echo);
			repeat ($urandom_range(0, 12)) begin
				case ($urandom_range(9))
					0:       send_tick(1'b1, echo);
					1:       send_tick(1'b1, $urandom_range(0, ECHO_TIMEOUT_US));
					default: send_tick(1'b0, $urandom_range(0, ECHO_TIMEOUT_US));
				endcase
			end
		end
	endtask

	initial begin
		bit          dir_act[20];
		int unsigned dir_echo[20];
		dir_act  = '{0, 1, 1, 1, 1, 1, 1, 1, 1, 1,
			1, 1, 0, 1, 1, 0, 1, 1, 1, 0};
		// zero echo, beyond range, max edge, safe and alert edges, tiny echoes
		dir_echo = '{30000, 0, 30000, 23201, 23200, 1451, 1450, 697, 696, 1,
			57, 58, 12345, 16384, 0, 21845, 1000, 600, 29999, 10922};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings
		for (int i = 0; i < 20; i++)
			send_tick(dir_act[i], dir_echo[i]);
		settings_used++;

		// short cadences
		configure(25, 12, 400, 1, 2, 3, 4);
		run_bursts(100);
		drain();
		run_bursts(100);

		// lowest limits, widest range, fastest cadence
		configure(0, 0, 517, 1, 1, 1, 1);
		send_tick(1'b1, 29986);
		send_tick(1'b1, 29987);
		send_tick(1'b1, ECHO_TIMEOUT_US);
		run_bursts(150);

		// crossed limits, no idling on either side
		jitter = 1'b0;
		configure(100, 300, 517, 5, 3, 7, 2);
		run_bursts(150);
		jitter = 1'b1;

		// narrowest range and longest cadences
		configure(517, 517, 1, 65535, 65535, 65535, 65535);
		send_tick(1'b1, 58);
		send_tick(1'b1, 59);
		run_bursts(100);

		repeat (4) begin
			configure($urandom_range(0, 517), $urandom_range(0, 517), $urandom_range(1, 517),
				$urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 12),
				$urandom_range(1, 40));
			run_bursts(130);
		end

		drain();
		repeat (8) @(negedge clk);

		$display("covered %0d ticks over %0d register settings, beeper on in %0d",
			board.checked, settings_used, board.beeps);
		$display("levels seen: safe %0d, alert %0d, danger %0d, sensor error %0d",
			board.level_seen[LVL_SAFE], board.level_seen[LVL_ALERT],
			board.level_seen[LVL_DANGER], board.level_seen[LVL_ERROR]);
		if (board.errors == 0 && board.pending() == 0)
			$display("PASS ultrasonic_level_alarm");
		else
			$display("FAIL ultrasonic_level_alarm");
		$finish;
	end

endmodule
